>>> design/quad_attitude_pid_mixer_top_defines.svh
// assertion macros shared by the attitude pid mixer rtl
// no dependencies; include by bare file name
`ifndef QUAD_ATTITUDE_PID_MIXER_TOP_DEFINES_SVH
`define QUAD_ATTITUDE_PID_MIXER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define QAPM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qapm assertion failed");
`define QAPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qapm assertion failed");
`else
`define QAPM_ASSERT_IMPL(label, ante, cons)
`define QAPM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/qapm_pkg.sv
// shared constants and types of the attitude pid mixer
// no dependencies
package qapm_pkg;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int ANGLE_W  = 16;
  localparam int ERR_W    = ANGLE_W + 1;
  localparam int DT_W     = 16;
  localparam int GAIN_W   = 16;
  localparam int GAINS_W  = 3 * GAIN_W;
  localparam int THR_W    = 13;
  localparam int DRIVE_W  = 14;
  localparam int MOTOR_W  = 13;
  localparam int Q12_ONE  = 4096;
  localparam int THR_MIN  = 410;
  localparam int NUM_AXES = 3;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ROLL  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PITCH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_YAW   = 2'd2;
  localparam int AXIS_ROLL  = 0;
  localparam int AXIS_PITCH = 1;
  localparam int AXIS_YAW   = 2;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctrl_t;

  typedef logic signed [DRIVE_W-1:0] drive_t;
  typedef logic [MOTOR_W-1:0] motor_t;
endpackage

>>> design/quad_attitude_pid_mixer_top.sv
// Attitude pid controller with x-quad motor mixer. Each input beat carries target and
// measured roll, pitch and yaw, a throttle and a time step; one output beat follows with
// four motor commands and the three clamped axis drives. Three pid lanes run side by side
// and a mixer merges them. Each lane finds its derivative term with a one-bit-per-cycle
// 48-bit divider, skipped when the time step is zero; one item is in flight at a time,
// and the next is taken while a result waits in the output register. Gains must be
// written through the cfg channel only while idle; the block itself does not enforce this.
`include "quad_attitude_pid_mixer_top_defines.svh"
module quad_attitude_pid_mixer_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // target_roll, target_pitch, target_yaw, target_throttle, measured_roll,
  // measured_pitch, measured_yaw, time_step
  input  logic [127:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // motor_front_left, motor_front_right, motor_back_left, motor_back_right,
  // roll_drive, pitch_drive, yaw_drive
  output logic [95:0]   out_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [qapm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [qapm_pkg::GAINS_W-1:0]   cfg_data
);
  localparam int F       = qapm_pkg::ANGLE_FRAC_BITS;
  localparam int EW      = qapm_pkg::ERR_W;
  localparam int AW      = qapm_pkg::ANGLE_W;
  localparam int MEAS_LSB = 3 * AW + qapm_pkg::THR_W;
  localparam int WRAP_W  = (F + 10 > EW) ? F + 10 : EW;
  localparam logic signed [WRAP_W-1:0] HALF_TURN = WRAP_W'(180 * (2 ** F));
  localparam logic signed [WRAP_W-1:0] FULL_TURN = WRAP_W'(360 * (2 ** F));
  localparam int WRAP_STEPS = (2 ** (EW - 1)) / (360 * (2 ** F)) + 1;

  logic [qapm_pkg::GAINS_W-1:0] gains_r [qapm_pkg::NUM_AXES];
  logic signed [EW-1:0] err_r [qapm_pkg::NUM_AXES];
  logic signed [EW-1:0] err_nxt [qapm_pkg::NUM_AXES];
  logic [qapm_pkg::DT_W-1:0]  dt_r;
  logic [qapm_pkg::THR_W-1:0] thr_r;
  logic busy_r, busy_nxt, start_r;
  logic out_valid_r, out_valid_nxt;
  logic [95:0] out_data_r;

  logic in_fire, load;
  logic [qapm_pkg::NUM_AXES-1:0] lane_done;
  qapm_pkg::drive_t drive [qapm_pkg::NUM_AXES];
  qapm_pkg::lane_ctrl_t ctrl;
  qapm_pkg::motor_t fl, fr, bl, br;
  logic signed [WRAP_W-1:0] yaw_w;

  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign load      = (&lane_done) && (!out_valid_r || out_tready);
  assign ctrl.start = start_r;
  assign ctrl.ack   = load;

  always_comb begin
    err_nxt[qapm_pkg::AXIS_ROLL] =
      EW'($signed(in_tdata[AW-1:0])) - EW'($signed(in_tdata[MEAS_LSB+AW-1:MEAS_LSB]));
    err_nxt[qapm_pkg::AXIS_PITCH] =
      EW'($signed(in_tdata[2*AW-1:AW])) -
      EW'($signed(in_tdata[MEAS_LSB+2*AW-1:MEAS_LSB+AW]));
    yaw_w = WRAP_W'($signed(in_tdata[3*AW-1:2*AW])) -
            WRAP_W'($signed(in_tdata[MEAS_LSB+3*AW-1:MEAS_LSB+2*AW]));
    for (int k = 0; k < WRAP_STEPS; k++) begin
      if (yaw_w > HALF_TURN) begin
        yaw_w = yaw_w - FULL_TURN;
      end else if (yaw_w < -HALF_TURN) begin
        yaw_w = yaw_w + FULL_TURN;
      end
    end
    err_nxt[qapm_pkg::AXIS_YAW] = EW'(yaw_w);
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
    end else if (load) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < qapm_pkg::NUM_AXES; k++) begin
        gains_r[k] <= '0;
      end
    end else begin
      busy_r      <= busy_nxt;
      start_r     <= in_fire;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          qapm_pkg::REG_ROLL:  gains_r[qapm_pkg::AXIS_ROLL]  <= cfg_data;
          qapm_pkg::REG_PITCH: gains_r[qapm_pkg::AXIS_PITCH] <= cfg_data;
          qapm_pkg::REG_YAW:   gains_r[qapm_pkg::AXIS_YAW]   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < qapm_pkg::NUM_AXES; k++) begin
        err_r[k] <= err_nxt[k];
      end
      thr_r <= in_tdata[3*AW+qapm_pkg::THR_W-1:3*AW];
      dt_r  <= in_tdata[6*AW+qapm_pkg::THR_W+qapm_pkg::DT_W-1:6*AW+qapm_pkg::THR_W];
    end
    if (load) begin
      out_data_r <= {2'b00, drive[qapm_pkg::AXIS_YAW], drive[qapm_pkg::AXIS_PITCH],
                     drive[qapm_pkg::AXIS_ROLL], br, bl, fr, fl};
    end
  end

  for (genvar g = 0; g < qapm_pkg::NUM_AXES; g++) begin : g_lane
    qapm_pid_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .gains (gains_r[g]),
      .err   (err_r[g]),
      .dt    (dt_r),
      .done  (lane_done[g]),
      .drive (drive[g])
    );
  end

  qapm_mixer u_mixer (
    .roll        (drive[qapm_pkg::AXIS_ROLL]),
    .pitch       (drive[qapm_pkg::AXIS_PITCH]),
    .yaw         (drive[qapm_pkg::AXIS_YAW]),
    .throttle    (thr_r),
    .front_left  (fl),
    .front_right (fr),
    .back_left   (bl),
    .back_right  (br)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `QAPM_ASSERT_NEXT(a_accept_busy, in_fire, busy_r && start_r)
  `QAPM_ASSERT_IMPL(a_start_busy, start_r, busy_r)
  `QAPM_ASSERT_IMPL(a_done_busy, (|lane_done), busy_r)
endmodule

>>> design/qapm_pid_lane.sv
// one pid axis: integral and previous error state, registered multiplies, serial divider
// depends on qapm_pkg and quad_attitude_pid_mixer_top_defines.svh
`include "quad_attitude_pid_mixer_top_defines.svh"
module qapm_pid_lane (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  qapm_pkg::lane_ctrl_t                   ctrl,
  input  logic [qapm_pkg::GAINS_W-1:0]           gains,
  input  logic signed [qapm_pkg::ERR_W-1:0]      err,
  input  logic [qapm_pkg::DT_W-1:0]              dt,
  output logic                                   done,
  output qapm_pkg::drive_t                       drive
);
  localparam int F       = qapm_pkg::ANGLE_FRAC_BITS;
  localparam int EW      = qapm_pkg::ERR_W;
  localparam int GW      = qapm_pkg::GAIN_W;
  localparam int DW      = qapm_pkg::DT_W;
  localparam int INTEG_W = F + 23;
  localparam int P_SHIFT = F - 4;
  localparam int I_SHIFT = F + 12;
  localparam int D_SHIFT = 20 - F;
  localparam int PP_W    = GW + 1 + EW;
  localparam int DF_W    = EW + 1;
  localparam int PD_W    = GW + 1 + DF_W;
  localparam int ID_W    = EW + DW + 1;
  localparam int IS_W    = ID_W + 1;
  localparam int IP_W    = GW + 1 + INTEG_W;
  localparam int NUM_W   = PD_W - 1 + D_SHIFT;
  localparam int DV_W    = NUM_W + 1;
  localparam int ACC_W   = NUM_W + 3;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam logic signed [INTEG_W-1:0] ILIM = INTEG_W'(50 * (2 ** (F + 16)));
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(qapm_pkg::Q12_ONE);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL1  = 7'b0000010,
    ST_INTEG = 7'b0000100,
    ST_MUL2  = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_SUM   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } lane_state_t;

  lane_state_t state_r, state_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [EW-1:0]      prev_r, prev_nxt;
  logic signed [PP_W-1:0]    pprod_r, pprod_nxt;
  logic signed [PD_W-1:0]    dprod_r, dprod_nxt;
  logic signed [ID_W-1:0]    idt_r, idt_nxt;
  logic signed [IP_W-1:0]    iprod_r, iprod_nxt;
  logic                      neg_r, neg_nxt;
  logic [NUM_W-1:0]          quo_r, quo_nxt;
  logic [DW:0]               rem_r, rem_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [qapm_pkg::DRIVE_W-1:0] drive_r, drive_nxt;

  logic signed [GW:0]        kp_s, ki_s, kd_s;
  logic signed [DF_W-1:0]    diff;
  logic signed [IS_W-1:0]    isum;
  logic [PD_W-1:0]           dmag;
  logic [DW:0]               trial;
  logic signed [PP_W-1:0]    p_val;
  logic signed [IP_W-1:0]    i_val;
  logic signed [DV_W-1:0]    d_val;
  logic signed [ACC_W-1:0]   acc;

  assign kp_s = $signed({1'b0, gains[3*GW-1:2*GW]});
  assign ki_s = $signed({1'b0, gains[2*GW-1:GW]});
  assign kd_s = $signed({1'b0, gains[GW-1:0]});
  assign diff = DF_W'(err) - DF_W'(prev_r);
  assign isum = IS_W'(integ_r) + IS_W'(idt_r);
  assign dmag = dprod_r[PD_W-1] ? PD_W'(-dprod_r) : PD_W'(dprod_r);
  assign trial = {rem_r[DW-1:0], quo_r[NUM_W-1]};
  assign p_val = pprod_r >>> P_SHIFT;
  assign i_val = iprod_r >>> I_SHIFT;

  always_comb begin
    if (dt == '0) begin
      d_val = '0;
    end else if (neg_r) begin
      d_val = -($signed({1'b0, quo_r}) + DV_W'(rem_r != '0));
    end else begin
      d_val = $signed({1'b0, quo_r});
    end
    acc = ACC_W'(p_val) + ACC_W'(i_val) + ACC_W'(d_val);
  end

  always_comb begin
    state_nxt = state_r;
    integ_nxt = integ_r;
    prev_nxt  = prev_r;
    pprod_nxt = pprod_r;
    dprod_nxt = dprod_r;
    idt_nxt   = idt_r;
    iprod_nxt = iprod_r;
    neg_nxt   = neg_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    drive_nxt = drive_r;
    case (state_r)
      ST_IDLE: begin
        if (ctrl.start) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        pprod_nxt = kp_s * err;
        dprod_nxt = kd_s * diff;
        idt_nxt   = err * $signed({1'b0, dt});
        prev_nxt  = err;
        state_nxt = ST_INTEG;
      end
      ST_INTEG: begin
        if (isum > IS_W'(ILIM)) begin
          integ_nxt = ILIM;
        end else if (isum < -IS_W'(ILIM)) begin
          integ_nxt = -ILIM;
        end else begin
          integ_nxt = INTEG_W'(isum);
        end
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        iprod_nxt = ki_s * integ_r;
        neg_nxt   = dprod_r[PD_W-1];
        quo_nxt   = {dmag[PD_W-2:0], {D_SHIFT{1'b0}}};
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(NUM_W - 1);
        state_nxt = (dt == '0) ? ST_SUM : ST_DIV;
      end
      ST_DIV: begin
        if (trial >= {1'b0, dt}) begin
          rem_nxt = trial - {1'b0, dt};
          quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (acc > SAT_HI) begin
          drive_nxt = qapm_pkg::DRIVE_W'(qapm_pkg::Q12_ONE);
        end else if (acc < -SAT_HI) begin
          drive_nxt = -qapm_pkg::DRIVE_W'(qapm_pkg::Q12_ONE);
        end else begin
          drive_nxt = qapm_pkg::DRIVE_W'(acc);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (ctrl.ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      integ_r <= '0;
      prev_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      integ_r <= integ_nxt;
      prev_r  <= prev_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pprod_r <= pprod_nxt;
    dprod_r <= dprod_nxt;
    idt_r   <= idt_nxt;
    iprod_r <= iprod_nxt;
    neg_r   <= neg_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    drive_r <= drive_nxt;
  end

  assign done  = (state_r == ST_DONE);
  assign drive = drive_r;

  `QAPM_ASSERT_IMPL(a_integ_lim, 1'b1, (integ_r <= ILIM) && (integ_r >= -ILIM))
  `QAPM_ASSERT_IMPL(a_start_idle, ctrl.start, state_r == ST_IDLE)
  `QAPM_ASSERT_IMPL(a_drive_lim, done,
    (drive_r <= qapm_pkg::DRIVE_W'(qapm_pkg::Q12_ONE)) &&
    (drive_r >= -qapm_pkg::DRIVE_W'(qapm_pkg::Q12_ONE)))
endmodule

>>> design/qapm_mixer.sv
// x-quad mixer: throttle clamp and four saturated motor commands
// depends on qapm_pkg
module qapm_mixer (
  input  qapm_pkg::drive_t               roll,
  input  qapm_pkg::drive_t               pitch,
  input  qapm_pkg::drive_t               yaw,
  input  logic [qapm_pkg::THR_W-1:0]     throttle,
  output qapm_pkg::motor_t               front_left,
  output qapm_pkg::motor_t               front_right,
  output qapm_pkg::motor_t               back_left,
  output qapm_pkg::motor_t               back_right
);
  localparam int MW = qapm_pkg::DRIVE_W + 3;

  logic signed [MW-1:0] t, r, p, y;
  logic signed [MW-1:0] fl, fr, bl, br;

  function automatic qapm_pkg::motor_t sat_motor(input logic signed [MW-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > MW'(qapm_pkg::Q12_ONE)) begin
      return qapm_pkg::MOTOR_W'(qapm_pkg::Q12_ONE);
    end else begin
      return qapm_pkg::MOTOR_W'(v);
    end
  endfunction

  always_comb begin
    if (throttle < qapm_pkg::THR_W'(qapm_pkg::THR_MIN)) begin
      t = MW'(qapm_pkg::THR_MIN);
    end else if (throttle > qapm_pkg::THR_W'(qapm_pkg::Q12_ONE)) begin
      t = MW'(qapm_pkg::Q12_ONE);
    end else begin
      t = $signed({{(MW - qapm_pkg::THR_W){1'b0}}, throttle});
    end
    r  = MW'(roll);
    p  = MW'(pitch);
    y  = MW'(yaw);
    fl = t - p + r - y;
    fr = t - p - r + y;
    bl = t + p + r + y;
    br = t + p - r - y;
  end

  assign front_left  = sat_motor(fl);
  assign front_right = sat_motor(fr);
  assign back_left   = sat_motor(bl);
  assign back_right  = sat_motor(br);
endmodule

>>> dv/tb_top.sv
// self-checking bench for quad_attitude_pid_mixer_top: random and corner attitude beats
// are checked field by field against a built-in fixed-point pid and x-quad mixer predictor
// depends on qapm_pkg and the rtl top only
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [qapm_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 70;

  typedef struct {
    logic signed [15:0] tgt_roll, tgt_pitch, tgt_yaw;
    logic [12:0] throttle;
    logic signed [15:0] meas_roll, meas_pitch, meas_yaw;
    logic [15:0] dt;
  } attitude_t;

  typedef struct {
    qapm_pkg::motor_t fl, fr, bl, br;
    qapm_pkg::drive_t roll, pitch, yaw;
  } motors_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [qapm_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [qapm_pkg::GAINS_W-1:0] cfg_data = '0;

  attitude_t ticks_pending[$];
  motors_t motors_expected[$];
  attitude_t tick_cur;
  logic [qapm_pkg::GAINS_W-1:0] axis_gains[qapm_pkg::NUM_AXES];
  longint integ_state[qapm_pkg::NUM_AXES];
  longint prev_err_state[qapm_pkg::NUM_AXES];
  int fails = 0;
  int ticks_sent = 0;
  int beats_seen = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit hold_ticks = 1'b1;
  bit quiet = 1'b0;

  always #6 clk = ~clk;

  quad_attitude_pid_mixer_top uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint axis_drive(int ax, longint err, longint dt);
    longint kp, ki, kd, ilim, p, i, d;
    kp = axis_gains[ax][47:32];
    ki = axis_gains[ax][31:16];
    kd = axis_gains[ax][15:0];
    ilim = 64'sd50 <<< (qapm_pkg::ANGLE_FRAC_BITS + 16);
    integ_state[ax] = clip(integ_state[ax] + err * dt, -ilim, ilim);
    p = floor_div(kp * err, 64'sd1 <<< (qapm_pkg::ANGLE_FRAC_BITS - 4));
    i = floor_div(ki * integ_state[ax], 64'sd1 <<< (qapm_pkg::ANGLE_FRAC_BITS + 12));
    d = 0;
    if (dt > 0)
      d = floor_div(kd * (err - prev_err_state[ax]) *
                    (64'sd1 <<< (20 - qapm_pkg::ANGLE_FRAC_BITS)), dt);
    prev_err_state[ax] = err;
    return clip(p + i + d, -qapm_pkg::Q12_ONE, qapm_pkg::Q12_ONE);
  endfunction

  function automatic motors_t mix_motors(attitude_t a);
    motors_t m;
    longint half_turn, full_turn, er, ep, ey, r, p, y, t, dt;
    half_turn = 64'sd180 <<< qapm_pkg::ANGLE_FRAC_BITS;
    full_turn = 64'sd360 <<< qapm_pkg::ANGLE_FRAC_BITS;
    er = longint'(a.tgt_roll) - longint'(a.meas_roll);
    ep = longint'(a.tgt_pitch) - longint'(a.meas_pitch);
    ey = longint'(a.tgt_yaw) - longint'(a.meas_yaw);
    dt = longint'(a.dt);
    while (ey > half_turn) ey -= full_turn;
    while (ey < -half_turn) ey += full_turn;
    r = axis_drive(qapm_pkg::AXIS_ROLL, er, dt);
    p = axis_drive(qapm_pkg::AXIS_PITCH, ep, dt);
    y = axis_drive(qapm_pkg::AXIS_YAW, ey, dt);
    t = clip(longint'(a.throttle), qapm_pkg::THR_MIN, qapm_pkg::Q12_ONE);
    m.fl = qapm_pkg::motor_t'(clip(t - p + r - y, 0, qapm_pkg::Q12_ONE));
    m.fr = qapm_pkg::motor_t'(clip(t - p - r + y, 0, qapm_pkg::Q12_ONE));
    m.bl = qapm_pkg::motor_t'(clip(t + p + r + y, 0, qapm_pkg::Q12_ONE));
    m.br = qapm_pkg::motor_t'(clip(t + p - r - y, 0, qapm_pkg::Q12_ONE));
    m.roll = qapm_pkg::drive_t'(r);
    m.pitch = qapm_pkg::drive_t'(p);
    m.yaw = qapm_pkg::drive_t'(y);
    return m;
  endfunction

  function automatic logic [127:0] pack_tick(attitude_t a);
    return {3'b0, a.dt, a.meas_yaw, a.meas_pitch, a.meas_roll, a.throttle,
            a.tgt_yaw, a.tgt_pitch, a.tgt_roll};
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    fails++;
    $display("beat %0d: %s got %0d expected %0d", beats_seen, field, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    logic nv;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        motors_expected.push_back(mix_motors(tick_cur));
        ticks_sent++;
      end
      if (!in_tvalid || in_tready) begin
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (!hold_ticks && ticks_pending.size() > 0) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            in_gap = $urandom_range(0, 4);
          end else begin
            tick_cur = ticks_pending.pop_front();
            in_tdata <= pack_tick(tick_cur);
            nv = 1'b1;
          end
        end
        in_tvalid <= nv;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    motors_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        beats_seen++;
        if (motors_expected.size() == 0) begin
          fails++;
          $display("result beat %0d arrived with nothing expected", beats_seen);
        end else begin
          want = motors_expected.pop_front();
          if (out_tdata[12:0] !== want.fl) report_mismatch("front_left", out_tdata[12:0], want.fl);
          if (out_tdata[25:13] !== want.fr)
            report_mismatch("front_right", out_tdata[25:13], want.fr);
          if (out_tdata[38:26] !== want.bl) report_mismatch("back_left", out_tdata[38:26], want.bl);
          if (out_tdata[51:39] !== want.br) report_mismatch("back_right", out_tdata[51:39], want.br);
          if (out_tdata[65:52] !== want.roll)
            report_mismatch("roll_drive", qapm_pkg::drive_t'(out_tdata[65:52]), want.roll);
          if (out_tdata[79:66] !== want.pitch)
            report_mismatch("pitch_drive", qapm_pkg::drive_t'(out_tdata[79:66]), want.pitch);
          if (out_tdata[93:80] !== want.yaw)
            report_mismatch("yaw_drive", qapm_pkg::drive_t'(out_tdata[93:80]), want.yaw);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", motors_expected.size());
      $display("quad_attitude_pid_mixer_top test failed");
      $finish;
    end
  end

  task automatic write_gains(logic [qapm_pkg::REG_IDX_W-1:0] idx,
                             logic [qapm_pkg::GAINS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == qapm_pkg::REG_ROLL) axis_gains[qapm_pkg::AXIS_ROLL] = val;
    else if (idx == qapm_pkg::REG_PITCH) axis_gains[qapm_pkg::AXIS_PITCH] = val;
    else if (idx == qapm_pkg::REG_YAW) axis_gains[qapm_pkg::AXIS_YAW] = val;
    @(posedge clk);
  endtask

  task automatic drain_ticks();
    hold_ticks = 1'b0;
    while (ticks_pending.size() > 0 || in_tvalid || in_gap > 0 || motors_expected.size() > 0)
      @(posedge clk);
    hold_ticks = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1) ? 23040 : -23040);
      default: return 16'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic attitude_t rand_tick();
    attitude_t a;
    a.tgt_roll = rand_angle();
    a.tgt_pitch = rand_angle();
    a.tgt_yaw = rand_angle();
    a.meas_roll = rand_angle();
    a.meas_pitch = rand_angle();
    a.meas_yaw = rand_angle();
    case ($urandom_range(0, 4))
      0: a.throttle = 13'($urandom);
      1: a.throttle = 13'($urandom_range(0, 500));
      default: a.throttle = 13'($urandom_range(1500, 3500));
    endcase
    case ($urandom_range(0, 7))
      0: a.dt = '0;
      1: a.dt = 16'($urandom);
      2: a.dt = 16'($urandom_range(1, 8));
      default: a.dt = 16'($urandom_range(30, 1200));
    endcase
    return a;
  endfunction

  function automatic attitude_t make_tick(int tr, int tp, int ty, int th,
                                          int mr, int mp, int my, int dt);
    attitude_t a;
    a.tgt_roll = 16'(tr); a.tgt_pitch = 16'(tp); a.tgt_yaw = 16'(ty);
    a.throttle = 13'(th);
    a.meas_roll = 16'(mr); a.meas_pitch = 16'(mp); a.meas_yaw = 16'(my);
    a.dt = 16'(dt);
    return a;
  endfunction

  function automatic logic [qapm_pkg::GAINS_W-1:0] rand_gains();
    if ($urandom_range(0, 3) == 0) return {16'($urandom), 16'($urandom), 16'($urandom)};
    return {16'($urandom_range(0, 1024)), 16'($urandom_range(0, 512)),
            16'($urandom_range(0, 64))};
  endfunction

  initial begin
    for (int k = 0; k < qapm_pkg::NUM_AXES; k++) begin
      axis_gains[k] = '0;
      integ_state[k] = 0;
      prev_err_state[k] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners with moderate gains
    write_gains(qapm_pkg::REG_ROLL, {16'd256, 16'd128, 16'd16});
    write_gains(qapm_pkg::REG_PITCH, {16'd384, 16'd64, 16'd8});
    write_gains(qapm_pkg::REG_YAW, {16'd200, 16'd32, 16'd4});
    write_gains(REG_SPARE, {qapm_pkg::GAINS_W{1'b1}});
    ticks_pending.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
    ticks_pending.push_back(make_tick(0, 0, 0, 4096, 0, 0, 0, 655));
    ticks_pending.push_back(make_tick(23040, -23040, 11520, 409, -23040, 23040, 0, 655));
    ticks_pending.push_back(make_tick(0, 0, -11520, 410, 0, 0, 0, 65535));
    ticks_pending.push_back(make_tick(0, 0, 11521, 411, 0, 0, 0, 1));
    ticks_pending.push_back(make_tick(0, 0, -11521, 8191, 0, 0, 0, 1));
    ticks_pending.push_back(make_tick(32767, -32768, 32767, 4097, -32768, 32767, -32768, 0));
    ticks_pending.push_back(make_tick(-32768, 32767, -32768, 2048, 32767, -32768, 32767, 65535));
    ticks_pending.push_back(make_tick(23040, 23040, 23040, 2048, -23040, -23040, -23040, 0));
    ticks_pending.push_back(make_tick(-64, 64, 0, 3000, 64, -64, 0, 100));
    ticks_pending.push_back(make_tick(0, 0, 0, 1, 0, 0, 0, 65535));
    ticks_pending.push_back(make_tick(-1, -1, -1, 4096, 1, 1, 1, 65535));
    for (int k = 0; k < 4; k++)
      ticks_pending.push_back(make_tick(5000, 5000, 5000, 2000, 0, 0, 0, 65535));
    for (int k = 0; k < 4; k++)
      ticks_pending.push_back(make_tick(-5000, -5000, -5000, 2000, 0, 0, 0, 65535));
    drain_ticks();

    // extreme gains
    write_gains(qapm_pkg::REG_ROLL, '1);
    write_gains(qapm_pkg::REG_PITCH, '1);
    write_gains(qapm_pkg::REG_YAW, '1);
    for (int k = 0; k < 40; k++) ticks_pending.push_back(rand_tick());
    drain_ticks();
    write_gains(qapm_pkg::REG_ROLL, '0);
    write_gains(qapm_pkg::REG_PITCH, '0);
    write_gains(qapm_pkg::REG_YAW, '0);
    for (int k = 0; k < 30; k++) ticks_pending.push_back(rand_tick());
    drain_ticks();

    for (int phase = 0; phase < 6; phase++) begin
      write_gains(qapm_pkg::REG_ROLL, rand_gains());
      write_gains(qapm_pkg::REG_PITCH, rand_gains());
      write_gains(qapm_pkg::REG_YAW, rand_gains());
      if (phase == 5) quiet = 1'b1;
      for (int k = 0; k < 150; k++) ticks_pending.push_back(rand_tick());
      drain_ticks();
    end

    $display("covered %0d ticks and %0d result beats over 9 gain settings,", ticks_sent,
             beats_seen);
    $display("with yaw wrap, zero and full time steps, and throttle and drive saturation");
    if (fails == 0 && motors_expected.size() == 0) begin
      $display("quad_attitude_pid_mixer_top test passed");
    end else begin
      $display("quad_attitude_pid_mixer_top test failed");
    end
    $finish;
  end
endmodule

>>> quad_attitude_pid_mixer_top.f
+incdir+design
design/qapm_pkg.sv
design/qapm_pid_lane.sv
design/qapm_mixer.sv
design/quad_attitude_pid_mixer_top.sv
dv/tb_top.sv
